@@ src/dbt_pkg.sv @@
// Shared types, codes and constants of the blink table.
`default_nettype none

package dbt_pkg;

  localparam int NUM_ENTRIES_DEF = 8;
  localparam int ID_WIDTH_DEF    = 8;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0] FOREVER_COUNT = 8'hFF;

  localparam logic [2:0] KIND_ADD    = 3'd0;
  localparam logic [2:0] KIND_FIND   = 3'd1;
  localparam logic [2:0] KIND_REMOVE = 3'd2;
  localparam logic [2:0] KIND_UPDATE = 3'd3;
  localparam logic [2:0] KIND_TICK   = 3'd4;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_FIND,
    OP_REMOVE,
    OP_UPDATE,
    OP_TICK,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] scan;
    logic [7:0] cur;
    logic [7:0] alt;
    logic [7:0] count;
    logic [3:0] idx;
    logic       idx_ok;
  } cmd_t;

  typedef struct packed {
    logic       write_scan;
    logic [7:0] scan_slot;
    logic [7:0] vector;
    logic [3:0] entry;
    logic       hit;
    logic       last;
  } res_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_status_t;

endpackage

`default_nettype wire

@@ src/dbt_front.sv @@
// Front end: takes command words and decodes them into queue entries.
`default_nettype none

module dbt_front #(
  parameter int NUM_ENTRIES = 8
) (
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [2:0]        in_kind,
  input  wire logic [7:0]        in_scan_slot,
  input  wire logic [7:0]        in_current_vector,
  input  wire logic [7:0]        in_alt_vector,
  input  wire logic [7:0]        in_blink_count,
  input  wire logic [3:0]        in_entry_index,
  input  wire dbt_pkg::q_status_t q_status,
  output logic                   push,
  output dbt_pkg::cmd_t          cmd
);
  import dbt_pkg::*;

  assign busy = q_status.full;
  assign push = start && !q_status.full;

  always_comb begin
    cmd.scan   = in_scan_slot;
    cmd.cur    = in_current_vector;
    cmd.alt    = in_alt_vector;
    cmd.count  = in_blink_count;
    cmd.idx    = in_entry_index;
    cmd.idx_ok = (int'(in_entry_index) < NUM_ENTRIES);
    unique case (in_kind)
      KIND_ADD:    cmd.op = OP_ADD;
      KIND_FIND:   cmd.op = OP_FIND;
      KIND_REMOVE: cmd.op = OP_REMOVE;
      KIND_UPDATE: cmd.op = OP_UPDATE;
      KIND_TICK:   cmd.op = OP_TICK;
      default:     cmd.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

@@ src/dbt_queue.sv @@
// Short command queue between the front end and the table engine.
`default_nettype none

module dbt_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire dbt_pkg::cmd_t      cmd_in,
  input  wire logic               pop,
  output dbt_pkg::q_status_t      q_status,
  output dbt_pkg::cmd_t           cmd_out
);
  import dbt_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] fill_r;

  assign q_status.full     = (fill_r == CNT_W'(QUEUE_DEPTH));
  assign q_status.nonempty = (fill_r != '0);
  assign cmd_out           = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + CNT_W'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ src/dbt_back.sv @@
// Table engine: holds the blink entries and walks them for add, find and tick commands.
`default_nettype none

module dbt_back #(
  parameter int NUM_ENTRIES = 8,
  parameter int ID_WIDTH    = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire dbt_pkg::cmd_t q_cmd,
  output logic               pop,
  output logic               res_valid,
  output dbt_pkg::res_t      res
);
  import dbt_pkg::*;

  localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam logic [3:0] NONE_ENTRY = 4'(NUM_ENTRIES);

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t                state_r;
  cmd_t                  cmd_r;
  logic [IDX_W-1:0]      ptr_r;
  logic                  res_valid_r;
  res_t                  res_r;

  logic [NUM_ENTRIES-1:0] valid_r;
  logic [NUM_ENTRIES-1:0] phase_r;
  logic [7:0]             scan_r   [NUM_ENTRIES];
  logic [ID_WIDTH-1:0]    vector_r [NUM_ENTRIES];
  logic [ID_WIDTH-1:0]    orig_r   [NUM_ENTRIES];
  logic [ID_WIDTH-1:0]    alt_r    [NUM_ENTRIES];
  logic [7:0]             count_r  [NUM_ENTRIES];

  logic [NUM_ENTRIES-1:0] above;
  logic                   higher;
  logic                   at_end;
  logic [7:0]             cnt_dec;
  logic [ID_WIDTH-1:0]    cur_id, alt_id;
  logic                   cur_valid;
  logic                   forever_cnt;

  function automatic res_t make_res(logic wr, logic [7:0] slot, logic [7:0] vec,
                                    logic [3:0] ent, logic hit, logic last);
    res_t r;
    r.write_scan = wr;
    r.scan_slot  = slot;
    r.vector     = vec;
    r.entry      = ent;
    r.hit        = hit;
    r.last       = last;
    return r;
  endfunction

  always_comb begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      above[i] = (IDX_W'(i) > ptr_r);
    end
  end

  assign higher      = |(valid_r & above);
  assign at_end      = (ptr_r == IDX_W'(NUM_ENTRIES - 1));
  assign cur_valid   = valid_r[ptr_r];
  assign cnt_dec     = count_r[ptr_r] - 8'd1;
  assign forever_cnt = (count_r[ptr_r] == FOREVER_COUNT);
  assign cur_id      = ID_WIDTH'(cmd_r.cur);
  assign alt_id      = ID_WIDTH'(cmd_r.alt);

  assign pop       = (state_r == ST_IDLE) && q_valid;
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ptr_r       <= '0;
      valid_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          res_valid_r <= 1'b0;
          if (q_valid) begin
            cmd_r   <= q_cmd;
            state_r <= ST_RUN;
            if (q_cmd.op == OP_REMOVE || q_cmd.op == OP_UPDATE) begin
              ptr_r <= IDX_W'(q_cmd.idx);
            end else begin
              ptr_r <= '0;
            end
          end
        end
        ST_RUN: begin
          unique case (cmd_r.op)
            OP_ADD: begin
              if (!cur_valid) begin
                valid_r[ptr_r]  <= 1'b1;
                phase_r[ptr_r]  <= 1'b1;
                scan_r[ptr_r]   <= cmd_r.scan;
                vector_r[ptr_r] <= cur_id;
                orig_r[ptr_r]   <= cur_id;
                alt_r[ptr_r]    <= alt_id;
                count_r[ptr_r]  <= cmd_r.count;
                res_r           <= make_res(1'b0, 8'd0, 8'd0, 4'(ptr_r), 1'b1, 1'b1);
                res_valid_r     <= 1'b1;
                state_r         <= ST_IDLE;
              end else if (at_end) begin
                res_r       <= make_res(1'b0, 8'd0, 8'd0, NONE_ENTRY, 1'b0, 1'b1);
                res_valid_r <= 1'b1;
                state_r     <= ST_IDLE;
              end else begin
                res_valid_r <= 1'b0;
                ptr_r       <= ptr_r + IDX_W'(1);
              end
            end
            OP_FIND: begin
              if (cur_valid && scan_r[ptr_r] == cmd_r.scan && alt_r[ptr_r] == alt_id) begin
                res_r       <= make_res(1'b0, 8'd0, 8'd0, 4'(ptr_r), 1'b1, 1'b1);
                res_valid_r <= 1'b1;
                state_r     <= ST_IDLE;
              end else if (at_end) begin
                res_r       <= make_res(1'b0, 8'd0, 8'd0, NONE_ENTRY, 1'b0, 1'b1);
                res_valid_r <= 1'b1;
                state_r     <= ST_IDLE;
              end else begin
                res_valid_r <= 1'b0;
                ptr_r       <= ptr_r + IDX_W'(1);
              end
            end
            OP_REMOVE: begin
              if (cmd_r.idx_ok && cur_valid) begin
                valid_r[ptr_r] <= 1'b0;
                res_r          <= make_res(1'b1, scan_r[ptr_r], 8'(orig_r[ptr_r]),
                                           NONE_ENTRY, 1'b0, 1'b1);
              end else begin
                res_r <= make_res(1'b0, 8'd0, 8'd0, NONE_ENTRY, 1'b0, 1'b1);
              end
              res_valid_r <= 1'b1;
              state_r     <= ST_IDLE;
            end
            OP_UPDATE: begin
              if (cmd_r.idx_ok && cur_valid && scan_r[ptr_r] == cmd_r.scan) begin
                vector_r[ptr_r] <= cur_id;
                orig_r[ptr_r]   <= cur_id;
              end
              res_r       <= make_res(1'b0, 8'd0, 8'd0, NONE_ENTRY, 1'b0, 1'b1);
              res_valid_r <= 1'b1;
              state_r     <= ST_IDLE;
            end
            OP_TICK: begin
              if (cur_valid) begin
                if (!forever_cnt && cnt_dec == 8'd0) begin
                  valid_r[ptr_r] <= 1'b0;
                  res_r          <= make_res(1'b1, scan_r[ptr_r], 8'(orig_r[ptr_r]),
                                             NONE_ENTRY, 1'b0, 1'b1);
                  res_valid_r    <= 1'b1;
                  state_r        <= ST_IDLE;
                end else begin
                  if (!forever_cnt) begin
                    count_r[ptr_r] <= cnt_dec;
                  end
                  phase_r[ptr_r] <= ~phase_r[ptr_r];
                  res_r          <= make_res(1'b1, scan_r[ptr_r],
                                             phase_r[ptr_r] ? 8'(alt_r[ptr_r])
                                                            : 8'(vector_r[ptr_r]),
                                             NONE_ENTRY, 1'b0, !higher);
                  res_valid_r    <= 1'b1;
                  if (higher) begin
                    ptr_r <= ptr_r + IDX_W'(1);
                  end else begin
                    state_r <= ST_IDLE;
                  end
                end
              end else if (at_end) begin
                res_r       <= make_res(1'b0, 8'd0, 8'd0, NONE_ENTRY, 1'b0, 1'b1);
                res_valid_r <= 1'b1;
                state_r     <= ST_IDLE;
              end else begin
                res_valid_r <= 1'b0;
                ptr_r       <= ptr_r + IDX_W'(1);
              end
            end
            default: begin
              res_r       <= make_res(1'b0, 8'd0, 8'd0, 4'd0, 1'b0, 1'b1);
              res_valid_r <= 1'b1;
              state_r     <= ST_IDLE;
            end
          endcase
        end
        default: begin
          res_valid_r <= 1'b0;
          state_r     <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/display_blink_table.sv @@
// Top level of the blink table: front end, command queue and table engine.
//
//   channel   ports                      word moved when
//   input     start/busy, in_*           start high and busy low at a clock edge
//   result    out_valid, out_*           out_valid high, each word shown for one cycle
//
// A word waits up to two deep in the queue while the engine works.
// Add, find and tick walk the table one entry per cycle, using the single entry
// pointer; remove and update go straight to the given index, and unused kinds
// do not walk the table. Tick results leave at most one per cycle.
// Synchronous reset empties the table and the queue at once.
// Results cannot be held off; busy rises only when the queue is full.
`default_nettype none

module display_blink_table #(
  parameter int NUM_ENTRIES = dbt_pkg::NUM_ENTRIES_DEF,
  parameter int ID_WIDTH    = dbt_pkg::ID_WIDTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] in_kind,
  input  wire logic [7:0] in_scan_slot,
  input  wire logic [7:0] in_current_vector,
  input  wire logic [7:0] in_alt_vector,
  input  wire logic [7:0] in_blink_count,
  input  wire logic [3:0] in_entry_index,
  output logic            out_valid,
  output logic            out_write_scan,
  output logic [7:0]      out_scan_slot,
  output logic [7:0]      out_vector,
  output logic [3:0]      out_entry,
  output logic            out_hit,
  output logic            out_last
);
  import dbt_pkg::*;

  q_status_t q_status;
  logic      push, pop;
  cmd_t      front_cmd, queue_cmd;
  res_t      res;

  dbt_front #(.NUM_ENTRIES(NUM_ENTRIES)) u_front (
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_scan_slot      (in_scan_slot),
    .in_current_vector (in_current_vector),
    .in_alt_vector     (in_alt_vector),
    .in_blink_count    (in_blink_count),
    .in_entry_index    (in_entry_index),
    .q_status          (q_status),
    .push              (push),
    .cmd               (front_cmd)
  );

  dbt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .cmd_in   (front_cmd),
    .pop      (pop),
    .q_status (q_status),
    .cmd_out  (queue_cmd)
  );

  dbt_back #(.NUM_ENTRIES(NUM_ENTRIES), .ID_WIDTH(ID_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_status.nonempty),
    .q_cmd     (queue_cmd),
    .pop       (pop),
    .res_valid (out_valid),
    .res       (res)
  );

  assign out_write_scan = res.write_scan;
  assign out_scan_slot  = res.scan_slot;
  assign out_vector     = res.vector;
  assign out_entry      = res.entry;
  assign out_hit        = res.hit;
  assign out_last       = res.last;

endmodule

`default_nettype wire

@@ src/dbt_checker.sv @@
// Port-level checks on the blink table and their attachment to the top level.
`default_nettype none

module dbt_checker #(
  parameter int NUM_ENTRIES = 8
) (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_write_scan,
  input wire logic [3:0] out_entry,
  input wire logic       out_hit,
  input wire logic       out_last
);

  localparam logic [3:0] NONE_ENTRY = 4'(NUM_ENTRIES);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word shown straight after reset");

  a_hit_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_write_scan && out_last)
    else $error("hit word writes the scan table or is not final");

  a_middle_writes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_write_scan && !out_hit)
    else $error("non-final result word is not a scan table write");

  a_write_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_scan |-> out_entry == NONE_ENTRY)
    else $error("scan table write names a table entry");

endmodule

bind display_blink_table dbt_checker #(.NUM_ENTRIES(NUM_ENTRIES)) u_dbt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_write_scan (out_write_scan),
  .out_entry      (out_entry),
  .out_hit        (out_hit),
  .out_last       (out_last)
);

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for the blink table: directed and random words against a predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dbt_pkg::*;

  localparam int N = NUM_ENTRIES_DEF;
  localparam logic [3:0] ENTRY_NONE = 4'(NUM_ENTRIES_DEF);
  localparam logic [2:0] KIND_LAST_CODE = 3'd7;
  localparam logic [3:0] INDEX_TOP = 4'hF;

  typedef struct packed {
    logic       valid;
    logic [7:0] scan;
    logic [7:0] vector;
    logic [7:0] original;
    logic [7:0] alternate;
    logic       phase;
    logic [7:0] count;
  } blink_entry_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic [2:0] in_kind = '0;
  logic [7:0] in_scan_slot = '0;
  logic [7:0] in_current_vector = '0;
  logic [7:0] in_alt_vector = '0;
  logic [7:0] in_blink_count = '0;
  logic [3:0] in_entry_index = '0;
  logic       busy;
  logic       out_valid;
  logic       out_write_scan;
  logic [7:0] out_scan_slot;
  logic [7:0] out_vector;
  logic [3:0] out_entry;
  logic       out_hit;
  logic       out_last;

  blink_entry_t blink_tbl [N];
  res_t         awaited_results [$];
  int           mismatches = 0;
  bit           gaps_on = 1'b1;

  display_blink_table dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_scan_slot(in_scan_slot),
    .in_current_vector(in_current_vector), .in_alt_vector(in_alt_vector),
    .in_blink_count(in_blink_count), .in_entry_index(in_entry_index),
    .out_valid(out_valid), .out_write_scan(out_write_scan),
    .out_scan_slot(out_scan_slot), .out_vector(out_vector),
    .out_entry(out_entry), .out_hit(out_hit), .out_last(out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
    mismatches++;
  endtask

  function automatic res_t result_word(logic wr, logic [7:0] slot, logic [7:0] vec,
                                       logic [3:0] ent, logic hit, logic last);
    res_t r;
    r.write_scan = wr;
    r.scan_slot  = slot;
    r.vector     = vec;
    r.entry      = ent;
    r.hit        = hit;
    r.last       = last;
    return r;
  endfunction

  function automatic void predict_tick();
    res_t       burst [N];
    int         n;
    bit         stop;
    logic [7:0] v;
    n = 0;
    stop = 1'b0;
    for (int i = 0; i < N && !stop; i++) begin
      if (blink_tbl[i].valid) begin
        if (blink_tbl[i].count != FOREVER_COUNT) begin
          blink_tbl[i].count = blink_tbl[i].count - 8'd1;
          if (blink_tbl[i].count == 8'd0) begin
            burst[n] = result_word(1'b1, blink_tbl[i].scan, blink_tbl[i].original,
                                   ENTRY_NONE, 1'b0, 1'b1);
            n++;
            blink_tbl[i] = '0;
            stop = 1'b1;
          end
        end
        if (!stop) begin
          v = blink_tbl[i].phase ? blink_tbl[i].alternate : blink_tbl[i].vector;
          blink_tbl[i].phase = ~blink_tbl[i].phase;
          burst[n] = result_word(1'b1, blink_tbl[i].scan, v, ENTRY_NONE, 1'b0, 1'b0);
          n++;
        end
      end
    end
    if (n == 0) begin
      awaited_results.push_back(result_word(1'b0, '0, '0, ENTRY_NONE, 1'b0, 1'b1));
    end else begin
      burst[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) awaited_results.push_back(burst[i]);
    end
  endfunction

  function automatic void predict_table_word(logic [2:0] kind, logic [7:0] slot,
                                             logic [7:0] cur, logic [7:0] alt,
                                             logic [7:0] cnt, logic [3:0] idx);
    int  found;
    bit  idx_live;
    found = -1;
    idx_live = (int'(idx) < N) && blink_tbl[idx].valid;
    case (kind)
      KIND_ADD: begin
        for (int i = 0; i < N; i++)
          if (found < 0 && !blink_tbl[i].valid) found = i;
        if (found >= 0) begin
          blink_tbl[found].valid     = 1'b1;
          blink_tbl[found].scan      = slot;
          blink_tbl[found].vector    = cur;
          blink_tbl[found].original  = cur;
          blink_tbl[found].alternate = alt;
          blink_tbl[found].phase     = 1'b1;
          blink_tbl[found].count     = cnt;
          awaited_results.push_back(result_word(1'b0, '0, '0, 4'(found), 1'b1, 1'b1));
        end else begin
          awaited_results.push_back(result_word(1'b0, '0, '0, ENTRY_NONE, 1'b0, 1'b1));
        end
      end
      KIND_FIND: begin
        for (int i = 0; i < N; i++)
          if (found < 0 && blink_tbl[i].valid && blink_tbl[i].scan == slot &&
              blink_tbl[i].alternate == alt) found = i;
        if (found >= 0)
          awaited_results.push_back(result_word(1'b0, '0, '0, 4'(found), 1'b1, 1'b1));
        else
          awaited_results.push_back(result_word(1'b0, '0, '0, ENTRY_NONE, 1'b0, 1'b1));
      end
      KIND_REMOVE: begin
        if (idx_live) begin
          awaited_results.push_back(result_word(1'b1, blink_tbl[idx].scan,
                                                blink_tbl[idx].original, ENTRY_NONE,
                                                1'b0, 1'b1));
          blink_tbl[idx] = '0;
        end else begin
          awaited_results.push_back(result_word(1'b0, '0, '0, ENTRY_NONE, 1'b0, 1'b1));
        end
      end
      KIND_UPDATE: begin
        if (idx_live && blink_tbl[idx].scan == slot) begin
          blink_tbl[idx].vector   = cur;
          blink_tbl[idx].original = cur;
        end
        awaited_results.push_back(result_word(1'b0, '0, '0, ENTRY_NONE, 1'b0, 1'b1));
      end
      KIND_TICK: predict_tick();
      default: awaited_results.push_back(result_word(1'b0, '0, '0, '0, 1'b0, 1'b1));
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic issue_word(input logic [2:0] kind, input logic [7:0] slot,
                            input logic [7:0] cur, input logic [7:0] alt,
                            input logic [7:0] cnt, input logic [3:0] idx);
    int gap;
    start             <= 1'b1;
    in_kind           <= kind;
    in_scan_slot      <= slot;
    in_current_vector <= cur;
    in_alt_vector     <= alt;
    in_blink_count    <= cnt;
    in_entry_index    <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_table_word(kind, slot, cur, alt, cnt, idx);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_quiet(input int settle);
    start <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_valid) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want = awaited_results.pop_front();
        if (out_write_scan != want.write_scan)
          report_mismatch("write_scan", int'(out_write_scan), int'(want.write_scan));
        if (out_scan_slot != want.scan_slot)
          report_mismatch("scan_slot", int'(out_scan_slot), int'(want.scan_slot));
        if (out_vector != want.vector)
          report_mismatch("vector", int'(out_vector), int'(want.vector));
        if (out_entry != want.entry)
          report_mismatch("entry", int'(out_entry), int'(want.entry));
        if (out_hit != want.hit) report_mismatch("hit", int'(out_hit), int'(want.hit));
        if (out_last != want.last) report_mismatch("last", int'(out_last), int'(want.last));
      end
    end
  end

  task automatic test_empty_and_expiry();
    issue_word(KIND_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
               4'($urandom));
    issue_word(KIND_ADD, 8'hFF, 8'hFF, 8'h00, FOREVER_COUNT, 4'($urandom));
    issue_word(KIND_ADD, 8'h00, 8'h00, 8'hFF, 8'h00, 4'($urandom));
    issue_word(KIND_ADD, 8'h5A, 8'hA5, 8'h3C, 8'h01, 4'($urandom));
    issue_word(KIND_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
               4'($urandom));
    issue_word(KIND_FIND, 8'hFF, 8'($urandom), 8'h00, 8'($urandom), 4'($urandom));
    issue_word(KIND_FIND, 8'h00, 8'($urandom), 8'h00, 8'($urandom), 4'($urandom));
  endtask

  task automatic test_update_paths();
    issue_word(KIND_UPDATE, 8'h00, 8'h77, 8'($urandom), 8'($urandom), 4'd1);
    issue_word(KIND_UPDATE, 8'h05, 8'h11, 8'($urandom), 8'($urandom), 4'd1);
    issue_word(KIND_UPDATE, 8'h00, 8'h22, 8'($urandom), 8'($urandom), ENTRY_NONE);
    issue_word(KIND_UPDATE, 8'h00, 8'h33, 8'($urandom), 8'($urandom), INDEX_TOP);
  endtask

  task automatic test_full_table();
    for (int i = 0; i < N - 1; i++)
      issue_word(KIND_ADD, 8'($urandom), 8'($urandom), 8'($urandom), FOREVER_COUNT,
                 4'($urandom));
    issue_word(KIND_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
               4'($urandom));
  endtask

  task automatic test_remove_and_unused();
    issue_word(KIND_REMOVE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
               INDEX_TOP);
    issue_word(KIND_REMOVE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
               ENTRY_NONE);
    issue_word(KIND_REMOVE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 4'd1);
    issue_word(KIND_REMOVE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 4'd1);
    for (int k = int'(KIND_TICK) + 1; k <= int'(KIND_LAST_CODE); k++)
      issue_word(3'(k), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 4'($urandom));
  endtask

  function automatic int pick_live();
    int live [$];
    for (int i = 0; i < N; i++)
      if (blink_tbl[i].valid) live.push_back(i);
    if (live.size() == 0) return -1;
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  function automatic logic [7:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 8'($urandom_range(1, 4));
    if (r < 65) return 8'($urandom_range(5, 20));
    if (r < 75) return 8'h00;
    if (r < 85) return FOREVER_COUNT;
    return 8'($urandom);
  endfunction

  task automatic test_random_mix(input int items, input bit with_gaps);
    int         done;
    int         r;
    int         li;
    logic [2:0] kind;
    logic [7:0] slot;
    logic [7:0] cur;
    logic [7:0] alt;
    logic [7:0] cnt;
    logic [3:0] idx;
    gaps_on = with_gaps;
    done = 0;
    while (done < items) begin
      r    = $urandom_range(0, 99);
      slot = 8'($urandom);
      cur  = 8'($urandom);
      alt  = 8'($urandom);
      cnt  = pick_count();
      idx  = 4'($urandom_range(0, 15));
      li   = pick_live();
      if (r < 26) begin
        kind = KIND_ADD;
        if ($urandom_range(0, 9) < 4) slot = 8'($urandom_range(0, 3));
        if ($urandom_range(0, 9) < 4) alt = 8'($urandom_range(0, 3));
      end else if (r < 56) begin
        kind = KIND_TICK;
      end else if (r < 70) begin
        kind = KIND_FIND;
        if (li >= 0 && $urandom_range(0, 3) != 0) begin
          slot = blink_tbl[li].scan;
          alt  = blink_tbl[li].alternate;
        end
      end else if (r < 81) begin
        kind = KIND_REMOVE;
        if (li >= 0 && $urandom_range(0, 3) != 0) idx = 4'(li);
      end else if (r < 92) begin
        kind = KIND_UPDATE;
        if (li >= 0 && $urandom_range(0, 3) != 0) begin
          idx  = 4'(li);
          slot = blink_tbl[li].scan;
        end
      end else begin
        kind = 3'($urandom_range(int'(KIND_TICK) + 1, int'(KIND_LAST_CODE)));
      end
      issue_word(kind, slot, cur, alt, cnt, idx);
      done++;
    end
  endtask

  initial begin
    timeout_guard: begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_and_expiry();
    test_update_paths();
    test_full_table();
    test_remove_and_unused();
    wait_for_quiet(N + 4);
    test_random_mix(110, 1'b1);
    wait_for_quiet(N + 4);
    test_random_mix(110, 1'b0);
    wait_for_quiet(N + 4);
    test_random_mix(190, 1'b1);
    wait_for_quiet(3 * (N + 2));
    if (awaited_results.size() != 0)
      report_mismatch("words still awaited", 0, awaited_results.size());
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
